FILE: rtl/assert_macros.svh
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// Antecedent implies consequent on the next edge.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ttc_pkg.sv
package ttc_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [47:0] LINGER_US   = 48'd300000;
    localparam logic [3:0]  MOVE_MM     = 4'd7;
    localparam logic [4:0]  SCROLL_X_MM = 5'd25;
    localparam logic [3:0]  SCROLL_Y_MM = 4'd15;

    typedef enum logic [1:0] {
        TH_NO    = 2'd0,
        TH_YES   = 2'd1,
        TH_MAYBE = 2'd2
    } thumb_t;

    typedef enum logic [2:0] {
        PH_NONE   = 3'd0,
        PH_HOVER  = 3'd1,
        PH_BEGIN  = 3'd2,
        PH_UPDATE = 3'd3,
        PH_END    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_RESET  = 2'd1,
        ACT_SUPP   = 2'd2,
        ACT_MULTI  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_ENABLE   = 3'd0,
        REG_UPPER    = 3'd1,
        REG_LOWER    = 3'd2,
        REG_SCROLL   = 3'd3,
        REG_PRESSURE = 3'd4,
        REG_SIZE     = 3'd5,
        REG_XRES     = 3'd6,
        REG_YRES     = 3'd7
    } cfg_reg_t;

    localparam logic [1:0] SCROLL_TWOFINGER = 2'd1;
    localparam logic [1:0] SCROLL_EDGE      = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_MUL5,
        ST_MUL6,
        ST_MUL7,
        ST_SCAN,
        ST_OTHER,
        ST_CLASS,
        ST_MF_SCAN,
        ST_MF_DEC,
        ST_OUT
    } state_t;

    function automatic logic is_active(input logic [2:0] ph);
        is_active = (ph == PH_BEGIN) || (ph == PH_UPDATE);
    endfunction

    function automatic logic is_down(input logic [2:0] ph);
        is_down = (ph == PH_BEGIN) || (ph == PH_UPDATE) || (ph == PH_END);
    endfunction

    function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

endpackage

FILE: rtl/ttc_mul.sv
module ttc_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod_reg
);

    logic [63:0] prod_next;

    assign prod_next = 64'(op_a) * 64'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

FILE: rtl/touchpad_thumb_classifier.sv
// Channel  Dir  Handshake                 Payload
// s_       in   s_tvalid / s_tready       s_tdata item fields, s_tuser action
// m_       out  m_tvalid / m_tready       m_tdata result fields
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item at a time; s_tready is high only in idle. Steps per item: reset/suppress
// and early-out updates go from load straight to the output register. Update:
// 8-slot scan, other-finger and classify steps; in the update phase the movement
// test (six products through the shared 32x32 multiplier, one compare) comes first.
// Movement over 7 mm ends the update there. Multifinger check: 8-slot scan plus decision.
// Result waits in the output register until m_tready; aresetn is synchronous.
module touchpad_thumb_classifier (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot, phase, pos_x, pos_y, touch_pressure, size_major, size_minor, now_us
    input  logic [135:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_slot, thumb_state, ignored, other_cleared, other_slot, pair_missing
    output logic [15:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int SW = ttc_pkg::SLOT_W;

    ttc_pkg::state_t state_reg, state_next;

    logic        en_reg;
    logic [15:0] upper_reg, lower_reg, plim_reg, slim_reg;
    logic [1:0]  scroll_reg;
    logic [9:0]  xres_reg, yres_reg;
    logic [9:0]  xr, yr;

    logic [1:0]  th_arr [ttc_pkg::SLOTS];
    logic [2:0]  ph_arr [ttc_pkg::SLOTS];
    logic [15:0] px_arr [ttc_pkg::SLOTS];
    logic [15:0] py_arr [ttc_pkg::SLOTS];
    logic [15:0] sx_arr [ttc_pkg::SLOTS];
    logic [15:0] sy_arr [ttc_pkg::SLOTS];
    logic [47:0] st_arr [ttc_pkg::SLOTS];

    logic [1:0]  act_reg;
    logic [2:0]  slot_reg, ph_reg;
    logic [15:0] x_reg, y_reg, pr_reg, mj_reg, mn_reg;
    logic [47:0] now_reg, tstart_reg;
    logic [1:0]  cur_reg;
    logic [15:0] dx_reg, dy_reg;
    logic [25:0] t1_reg, t2_reg;
    logic [22:0] t3_reg;
    logic [52:0] acc_reg;
    logic [SW-1:0] idx_reg, fidx_reg, sidx_reg;
    logic [1:0]  cnt_reg;
    logic        found_reg, fthumb_maybe_reg;
    logic        fok_reg, sok_reg;
    logic [15:0] fx_reg, fy_reg, sx_reg, sy_reg;

    logic [2:0]  o_slot_reg, o_os_reg;
    logic [1:0]  o_th_reg;
    logic        o_oc_reg, o_pm_reg;

    logic [SW-1:0] rd_addr, slot_idx;
    logic [1:0]  rd_th;
    logic [2:0]  rd_ph;
    logic [15:0] rd_px, rd_py;
    logic        slot_ok, idx_last, accept;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [48:0] linger_end;
    logic        excl, thumb_hit, close;
    logic [18:0] minor5, size3;
    logic [14:0] xlim;
    logic [13:0] ylim;
    logic [12:0] yr7;

    assign xr = (xres_reg == 10'd0) ? 10'd1 : xres_reg;
    assign yr = (yres_reg == 10'd0) ? 10'd1 : yres_reg;
    assign slot_idx = SW'(slot_reg);
    assign slot_ok  = 32'(slot_reg) < ttc_pkg::SLOTS;
    assign idx_last = 32'(idx_reg) == ttc_pkg::SLOTS - 1;
    assign accept   = s_tvalid && s_tready;

    assign s_tready  = (state_reg == ttc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ttc_pkg::ST_OUT);
    assign m_tdata   = {5'd0, o_pm_reg, o_os_reg, o_oc_reg, o_th_reg == ttc_pkg::TH_YES,
                        o_th_reg, o_slot_reg};

    always_comb begin
        case (state_reg)
            ttc_pkg::ST_SCAN, ttc_pkg::ST_MF_SCAN: rd_addr = idx_reg;
            ttc_pkg::ST_MF_DEC:                    rd_addr = sidx_reg;
            default:                               rd_addr = slot_idx;
        endcase
    end

    assign rd_th = th_arr[rd_addr];
    assign rd_ph = ph_arr[rd_addr];
    assign rd_px = px_arr[rd_addr];
    assign rd_py = py_arr[rd_addr];

    assign yr7 = 13'(yr) * 13'(ttc_pkg::MOVE_MM);

    always_comb begin
        case (state_reg)
            ttc_pkg::ST_MUL1: begin mul_a = 32'(dx_reg); mul_b = 32'(yr);  end
            ttc_pkg::ST_MUL2: begin mul_a = 32'(dy_reg); mul_b = 32'(xr);  end
            ttc_pkg::ST_MUL3: begin mul_a = 32'(xr);     mul_b = 32'(yr7); end
            ttc_pkg::ST_MUL4: begin mul_a = 32'(t1_reg); mul_b = 32'(t1_reg); end
            ttc_pkg::ST_MUL5: begin mul_a = 32'(t2_reg); mul_b = 32'(t2_reg); end
            ttc_pkg::ST_MUL6: begin mul_a = 32'(t3_reg); mul_b = 32'(t3_reg); end
            default:          begin mul_a = 32'd0;       mul_b = 32'd0;       end
        endcase
    end

    ttc_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    assign linger_end = 49'(tstart_reg) + 49'(ttc_pkg::LINGER_US);
    assign excl = (y_reg > lower_reg) && (scroll_reg != ttc_pkg::SCROLL_EDGE) &&
                  (linger_end < 49'(now_reg));
    assign minor5 = 19'(mn_reg) * 19'd5;
    assign size3  = 19'(slim_reg) * 19'd3;
    assign thumb_hit = ((plim_reg != 16'hFFFF) && (pr_reg > plim_reg) && excl) ||
                       ((slim_reg != 16'd0) && (mj_reg > slim_reg) && (minor5 < size3)) ||
                       excl;
    assign xlim  = 15'(xr) * 15'(ttc_pkg::SCROLL_X_MM);
    assign ylim  = 14'(yr) * 14'(ttc_pkg::SCROLL_Y_MM);
    assign close = (scroll_reg == ttc_pkg::SCROLL_TWOFINGER) &&
                   (17'(ttc_pkg::absdiff(fx_reg, sx_reg)) <= 17'(xlim)) &&
                   (17'(ttc_pkg::absdiff(fy_reg, sy_reg)) <= 17'(ylim));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ttc_pkg::ST_IDLE: if (accept) state_next = ttc_pkg::ST_LOAD;
            ttc_pkg::ST_LOAD: begin
                if (act_reg == ttc_pkg::ACT_MULTI) begin
                    state_next = ttc_pkg::ST_MF_SCAN;
                end else if (!slot_ok || act_reg != ttc_pkg::ACT_UPDATE) begin
                    state_next = ttc_pkg::ST_OUT;
                end else if (!en_reg || rd_th != ttc_pkg::TH_MAYBE || y_reg < upper_reg) begin
                    state_next = ttc_pkg::ST_OUT;
                end else if (ph_reg == ttc_pkg::PH_UPDATE) begin
                    state_next = ttc_pkg::ST_MUL1;
                end else begin
                    state_next = ttc_pkg::ST_SCAN;
                end
            end
            ttc_pkg::ST_MUL1: state_next = ttc_pkg::ST_MUL2;
            ttc_pkg::ST_MUL2: state_next = ttc_pkg::ST_MUL3;
            ttc_pkg::ST_MUL3: state_next = ttc_pkg::ST_MUL4;
            ttc_pkg::ST_MUL4: state_next = ttc_pkg::ST_MUL5;
            ttc_pkg::ST_MUL5: state_next = ttc_pkg::ST_MUL6;
            ttc_pkg::ST_MUL6: state_next = ttc_pkg::ST_MUL7;
            ttc_pkg::ST_MUL7: begin
                if (acc_reg > prod[52:0]) state_next = ttc_pkg::ST_OUT;
                else                      state_next = ttc_pkg::ST_SCAN;
            end
            ttc_pkg::ST_SCAN:    if (idx_last) state_next = ttc_pkg::ST_OTHER;
            ttc_pkg::ST_OTHER:   state_next = ttc_pkg::ST_CLASS;
            ttc_pkg::ST_CLASS:   state_next = ttc_pkg::ST_OUT;
            ttc_pkg::ST_MF_SCAN: if (idx_last) state_next = ttc_pkg::ST_MF_DEC;
            ttc_pkg::ST_MF_DEC:  state_next = ttc_pkg::ST_OUT;
            ttc_pkg::ST_OUT:     if (m_tready) state_next = ttc_pkg::ST_IDLE;
            default:             state_next = ttc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ttc_pkg::ST_IDLE;
            en_reg     <= 1'b0;
            upper_reg  <= 16'hFFFF;
            lower_reg  <= 16'hFFFF;
            scroll_reg <= 2'd0;
            plim_reg   <= 16'hFFFF;
            slim_reg   <= 16'd0;
            xres_reg   <= 10'd1;
            yres_reg   <= 10'd1;
            for (int i = 0; i < ttc_pkg::SLOTS; i++) begin
                th_arr[i] <= ttc_pkg::TH_MAYBE;
                ph_arr[i] <= ttc_pkg::PH_NONE;
                px_arr[i] <= 16'd0;
                py_arr[i] <= 16'd0;
                st_arr[i] <= 48'd0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ttc_pkg::REG_ENABLE:   en_reg     <= cfg_data[0];
                    ttc_pkg::REG_UPPER:    upper_reg  <= cfg_data;
                    ttc_pkg::REG_LOWER:    lower_reg  <= cfg_data;
                    ttc_pkg::REG_SCROLL:   scroll_reg <= cfg_data[1:0];
                    ttc_pkg::REG_PRESSURE: plim_reg   <= cfg_data;
                    ttc_pkg::REG_SIZE:     slim_reg   <= cfg_data;
                    ttc_pkg::REG_XRES:     xres_reg   <= cfg_data[9:0];
                    ttc_pkg::REG_YRES:     yres_reg   <= cfg_data[9:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ttc_pkg::ST_LOAD: begin
                    if (act_reg != ttc_pkg::ACT_MULTI && slot_ok) begin
                        case (act_reg)
                            ttc_pkg::ACT_RESET: th_arr[slot_idx] <= ttc_pkg::TH_MAYBE;
                            ttc_pkg::ACT_SUPP:  th_arr[slot_idx] <= ttc_pkg::TH_YES;
                            default: begin
                                ph_arr[slot_idx] <= ph_reg;
                                px_arr[slot_idx] <= x_reg;
                                py_arr[slot_idx] <= y_reg;
                                if (ph_reg == ttc_pkg::PH_BEGIN)
                                    st_arr[slot_idx] <= now_reg;
                                if (en_reg && rd_th == ttc_pkg::TH_MAYBE &&
                                    y_reg < upper_reg)
                                    th_arr[slot_idx] <= ttc_pkg::TH_NO;
                            end
                        endcase
                    end
                end
                ttc_pkg::ST_MUL7: begin
                    if (acc_reg > prod[52:0]) th_arr[slot_idx] <= ttc_pkg::TH_NO;
                end
                ttc_pkg::ST_OTHER: begin
                    if (y_reg > upper_reg && cnt_reg == 2'd2 && found_reg &&
                        fidx_reg != slot_idx && fthumb_maybe_reg)
                        th_arr[fidx_reg] <= ttc_pkg::TH_NO;
                end
                ttc_pkg::ST_CLASS: th_arr[slot_idx] <= thumb_hit ? ttc_pkg::TH_YES : cur_reg;
                ttc_pkg::ST_MF_DEC: begin
                    if (fok_reg && sok_reg && !close) th_arr[sidx_reg] <= ttc_pkg::TH_YES;
                end
                default: ;
            endcase
        end
    end

    // start position store has no reset
    always_ff @(posedge aclk) begin
        if (state_reg == ttc_pkg::ST_LOAD && act_reg == ttc_pkg::ACT_UPDATE && slot_ok &&
            en_reg && rd_th == ttc_pkg::TH_MAYBE && !(y_reg < upper_reg) &&
            ph_reg == ttc_pkg::PH_BEGIN) begin
            sx_arr[slot_idx] <= x_reg;
            sy_arr[slot_idx] <= y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ttc_pkg::ST_IDLE: begin
                if (accept) begin
                    act_reg  <= s_tuser;
                    slot_reg <= s_tdata[2:0];
                    ph_reg   <= s_tdata[5:3];
                    x_reg    <= s_tdata[21:6];
                    y_reg    <= s_tdata[37:22];
                    pr_reg   <= s_tdata[53:38];
                    mj_reg   <= s_tdata[69:54];
                    mn_reg   <= s_tdata[85:70];
                    now_reg  <= s_tdata[133:86];
                end
            end
            ttc_pkg::ST_LOAD: begin
                idx_reg   <= '0;
                cnt_reg   <= 2'd0;
                found_reg <= 1'b0;
                fok_reg   <= 1'b0;
                sok_reg   <= 1'b0;
                o_oc_reg  <= 1'b0;
                o_os_reg  <= 3'd0;
                o_pm_reg  <= 1'b0;
                o_slot_reg <= slot_reg;
                cur_reg   <= rd_th;
                tstart_reg <= (ph_reg == ttc_pkg::PH_BEGIN) ? now_reg : st_arr[slot_idx];
                dx_reg    <= ttc_pkg::absdiff(x_reg, sx_arr[slot_idx]);
                dy_reg    <= ttc_pkg::absdiff(y_reg, sy_arr[slot_idx]);
                if (!slot_ok) begin
                    o_th_reg <= ttc_pkg::TH_NO;
                end else if (act_reg == ttc_pkg::ACT_RESET) begin
                    o_th_reg <= ttc_pkg::TH_MAYBE;
                end else if (act_reg == ttc_pkg::ACT_SUPP) begin
                    o_th_reg <= ttc_pkg::TH_YES;
                end else if (en_reg && rd_th == ttc_pkg::TH_MAYBE && y_reg < upper_reg) begin
                    o_th_reg <= ttc_pkg::TH_NO;
                end else begin
                    o_th_reg <= rd_th;
                end
            end
            ttc_pkg::ST_MUL2: t1_reg <= prod[25:0];
            ttc_pkg::ST_MUL3: t2_reg <= prod[25:0];
            ttc_pkg::ST_MUL4: t3_reg <= prod[22:0];
            ttc_pkg::ST_MUL5: acc_reg <= prod[52:0];
            ttc_pkg::ST_MUL6: acc_reg <= acc_reg + prod[52:0];
            ttc_pkg::ST_MUL7: o_th_reg <= ttc_pkg::TH_NO;
            ttc_pkg::ST_SCAN: begin
                idx_reg <= idx_reg + SW'(1);
                if (ttc_pkg::is_active(rd_ph)) begin
                    if (cnt_reg != 2'd2) cnt_reg <= cnt_reg + 2'd1;
                    if (!found_reg && rd_py > upper_reg) begin
                        found_reg        <= 1'b1;
                        fidx_reg         <= idx_reg;
                        fthumb_maybe_reg <= (rd_th == ttc_pkg::TH_MAYBE);
                    end
                end
            end
            ttc_pkg::ST_OTHER: begin
                if (y_reg > upper_reg && cnt_reg == 2'd2 && found_reg) begin
                    cur_reg <= ttc_pkg::TH_NO;
                    if (fidx_reg != slot_idx && fthumb_maybe_reg) begin
                        o_oc_reg <= 1'b1;
                        o_os_reg <= 3'(fidx_reg);
                    end
                end
            end
            ttc_pkg::ST_CLASS: o_th_reg <= thumb_hit ? ttc_pkg::TH_YES : cur_reg;
            ttc_pkg::ST_MF_SCAN: begin
                idx_reg <= idx_reg + SW'(1);
                if (!(fok_reg && sok_reg) && ttc_pkg::is_down(rd_ph)) begin
                    if (rd_ph != ttc_pkg::PH_BEGIN) begin
                        fok_reg <= 1'b1;
                        fidx_reg <= idx_reg;
                        fx_reg <= rd_px;
                        fy_reg <= rd_py;
                    end else begin
                        sok_reg <= 1'b1;
                        sidx_reg <= idx_reg;
                        sx_reg <= rd_px;
                        sy_reg <= rd_py;
                    end
                end
            end
            ttc_pkg::ST_MF_DEC: begin
                if (!(fok_reg && sok_reg)) begin
                    o_slot_reg <= 3'd0;
                    o_th_reg   <= ttc_pkg::TH_NO;
                    o_pm_reg   <= 1'b1;
                end else begin
                    o_slot_reg <= 3'(sidx_reg);
                    o_th_reg   <= close ? rd_th : ttc_pkg::TH_YES;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/ttc_checker.sv
`include "assert_macros.svh"

module ttc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata
);

    `CHK_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
    `CHK_ALWAYS(a_one_item, aclk, aresetn, !(s_tready && m_tvalid), "input open while result pending")
    `CHK_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted twice")
    `CHK_ALWAYS(a_ignored, aclk, aresetn, !m_tvalid || (m_tdata[5] == (m_tdata[4:3] == 2'd1)), "ignored flag mismatch")
    `CHK_ALWAYS(a_pair_missing, aclk, aresetn, !m_tvalid || !m_tdata[10] || (m_tdata[4:0] == 5'd0 && !m_tdata[6]), "bad missing pair result")

endmodule

bind touchpad_thumb_classifier ttc_checker u_ttc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
